>>> hw/rtl/wav_sampler_loop_extractor_core_assert.svh
// assertion macros shared by the queue and back-end rtl files
`ifndef WAV_SAMPLER_LOOP_EXTRACTOR_CORE_ASSERT_SVH
`define WAV_SAMPLER_LOOP_EXTRACTOR_CORE_ASSERT_SVH

// property checked at every clock edge outside reset
`define WSLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define WSLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/wsle_pkg.sv
`timescale 1ns / 1ps

package wsle_pkg;

	// depth of the queue between parser and loop extractor
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// sampler chunk data byte positions
	localparam logic [5:0] IDX_COUNT_LAST = 6'd31;
	localparam logic [5:0] IDX_START_LAST = 6'd47;
	localparam logic [5:0] IDX_END_LAST   = 6'd51;
	localparam logic [5:0] IDX_DONE       = 6'd59;
	localparam logic [5:0] IDX_MAX        = 6'd63;

	// header and chunk header lengths
	localparam logic [5:0] HDR_LEN       = 6'd12;
	localparam logic [5:0] CHUNK_HDR_LEN = 6'd8;

	typedef enum logic [2:0] {
		FS_HEADER,
		FS_CHUNK,
		FS_SKIP,
		FS_SAMPLER,
		FS_DONE
	} front_state_t;

	typedef enum logic [1:0] {
		OP_DATA,
		OP_FAIL,
		OP_END
	} op_t;

	// one queued operation for the loop extractor
	typedef struct packed {
		op_t        op;
		logic [5:0] idx;
		logic [7:0] data;
		logic       last;
	} qent_t;

	function automatic logic [7:0] riff_byte(input logic [1:0] i);
		logic [7:0] r;
		unique case (i)
			2'd0: r = 8'h52;
			2'd1: r = 8'h49;
			2'd2: r = 8'h46;
			default: r = 8'h46;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] wave_byte(input logic [1:0] i);
		logic [7:0] r;
		unique case (i)
			2'd0: r = 8'h57;
			2'd1: r = 8'h41;
			2'd2: r = 8'h56;
			default: r = 8'h45;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] smpl_byte(input logic [1:0] i);
		logic [7:0] r;
		unique case (i)
			2'd0: r = 8'h73;
			2'd1: r = 8'h6D;
			2'd2: r = 8'h70;
			default: r = 8'h6C;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/wsle_front.sv
`timescale 1ns / 1ps

module wsle_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	input  logic           q_full,
	output logic           push,
	output wsle_pkg::qent_t push_ent
);

	wsle_pkg::front_state_t state_q, state_d;
	logic [5:0]  idx_q, idx_d;
	logic [31:0] ws_q, ws_d;
	logic        smp_q, smp_d;
	logic [32:0] skip_q, skip_d;
	logic        acc;
	logic        mism;
	logic [31:0] ws_shift;
	logic [32:0] skip_new;

	assign in_ready = !q_full;
	assign acc      = in_valid && !q_full;
	assign ws_shift = {in_byte, ws_q[31:8]};
	assign skip_new = {1'b0, ws_shift} + {32'd0, ws_shift[0]};

	// tag mismatch in the file header
	always_comb begin
		mism = 1'b0;
		if (idx_q < 6'd4 && in_byte != wsle_pkg::riff_byte(idx_q[1:0])) begin
			mism = 1'b1;
		end
		if (idx_q >= 6'd8 && idx_q < wsle_pkg::HDR_LEN &&
				in_byte != wsle_pkg::wave_byte(idx_q[1:0])) begin
			mism = 1'b1;
		end
	end

	// next state and queue push
	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		ws_d          = ws_q;
		smp_d         = smp_q;
		skip_d        = skip_q;
		push          = 1'b0;
		push_ent.op   = wsle_pkg::OP_END;
		push_ent.idx  = idx_q;
		push_ent.data = in_byte;
		push_ent.last = in_last;
		unique case (state_q)
			wsle_pkg::FS_HEADER: begin
				if (mism) begin
					push        = 1'b1;
					push_ent.op = wsle_pkg::OP_FAIL;
					state_d     = wsle_pkg::FS_DONE;
				end else if (idx_q + 6'd1 >= wsle_pkg::HDR_LEN) begin
					state_d = wsle_pkg::FS_CHUNK;
					idx_d   = '0;
					smp_d   = 1'b1;
				end else begin
					idx_d = idx_q + 6'd1;
				end
			end
			wsle_pkg::FS_CHUNK: begin
				ws_d  = ws_shift;
				idx_d = idx_q + 6'd1;
				if (idx_q < 6'd4 && in_byte != wsle_pkg::smpl_byte(idx_q[1:0])) begin
					smp_d = 1'b0;
				end
				if (idx_q + 6'd1 >= wsle_pkg::CHUNK_HDR_LEN) begin
					idx_d = '0;
					if (smp_q) begin
						state_d = wsle_pkg::FS_SAMPLER;
					end else if (skip_new == 33'd0) begin
						smp_d = 1'b1;
					end else begin
						skip_d  = skip_new;
						state_d = wsle_pkg::FS_SKIP;
					end
				end
			end
			wsle_pkg::FS_SKIP: begin
				if (skip_q <= 33'd1) begin
					skip_d  = '0;
					state_d = wsle_pkg::FS_CHUNK;
					idx_d   = '0;
					smp_d   = 1'b1;
				end else begin
					skip_d = skip_q - 33'd1;
				end
			end
			wsle_pkg::FS_SAMPLER: begin
				push        = 1'b1;
				push_ent.op = wsle_pkg::OP_DATA;
				if (idx_q < wsle_pkg::IDX_MAX) begin
					idx_d = idx_q + 6'd1;
				end
			end
			wsle_pkg::FS_DONE: begin
			end
			default: begin
				state_d = wsle_pkg::FS_DONE;
			end
		endcase
		// final byte closes the file and rearms the parser
		if (in_last) begin
			if (state_q != wsle_pkg::FS_DONE && !push) begin
				push        = 1'b1;
				push_ent.op = wsle_pkg::OP_END;
			end
			state_d = wsle_pkg::FS_HEADER;
			idx_d   = '0;
			ws_d    = '0;
			smp_d   = 1'b0;
			skip_d  = '0;
		end
		if (!acc) begin
			push = 1'b0;
		end
	end

	// parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsle_pkg::FS_HEADER;
			idx_q   <= '0;
			ws_q    <= '0;
			smp_q   <= 1'b0;
			skip_q  <= '0;
		end else if (acc) begin
			state_q <= state_d;
			idx_q   <= idx_d;
			ws_q    <= ws_d;
			smp_q   <= smp_d;
			skip_q  <= skip_d;
		end
	end

endmodule

>>> hw/rtl/wsle_queue.sv
`timescale 1ns / 1ps
`include "wav_sampler_loop_extractor_core_assert.svh"

module wsle_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsle_pkg::qent_t push_ent,
	output logic            full,
	output logic            head_valid,
	output wsle_pkg::qent_t head_ent,
	input  logic            pop
);

	wsle_pkg::qent_t                 mem_q [wsle_pkg::QDEPTH];
	logic [wsle_pkg::QPTR_W-1:0]     wr_q;
	logic [wsle_pkg::QPTR_W-1:0]     rd_q;
	logic [wsle_pkg::QCNT_W-1:0]     cnt_q;
	logic                            do_push;
	logic                            do_pop;

	localparam logic [wsle_pkg::QPTR_W-1:0] PTR_LAST = wsle_pkg::QPTR_W'(wsle_pkg::QDEPTH - 1);
	localparam logic [wsle_pkg::QCNT_W-1:0] CNT_FULL = wsle_pkg::QCNT_W'(wsle_pkg::QDEPTH);

	assign full       = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head_ent   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_ent;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`WSLE_ASSERT(a_q_no_overflow, !(push && full), "push into a full queue")
	`WSLE_ASSERT(a_q_count_bound, cnt_q <= CNT_FULL, "queue count above depth")
	`WSLE_ASSERT_NEXT(a_q_push_seen, do_push && !do_pop, head_valid, "queue empty after push")

endmodule

>>> hw/rtl/wsle_back.sv
`timescale 1ns / 1ps
`include "wav_sampler_loop_extractor_core_assert.svh"

module wsle_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  wsle_pkg::qent_t head_ent,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            out_found,
	output logic [31:0]     out_start,
	output logic [31:0]     out_length
);

	logic        sent_q, sent_d;
	logic [31:0] ws_q, ws_d;
	logic [31:0] lb_q, lb_d;
	logic [31:0] ws_new;
	logic [31:0] ws_diff;
	logic        fire;
	logic        res_found;
	logic [31:0] res_start;
	logic [31:0] res_len;
	logic        vld_q;
	logic        found_q;
	logic [31:0] start_q;
	logic [31:0] len_q;

	assign pop     = head_valid && (!vld_q || out_ready);
	assign ws_new  = (head_ent.idx <= wsle_pkg::IDX_END_LAST) ?
		{head_ent.data, ws_q[31:8]} : ws_q;
	assign ws_diff = ws_new - lb_q;

	// loop field extraction and outcome
	always_comb begin
		sent_d    = sent_q;
		ws_d      = ws_q;
		lb_d      = lb_q;
		fire      = 1'b0;
		res_found = 1'b0;
		res_start = '0;
		res_len   = '0;
		case (head_ent.op)
			wsle_pkg::OP_DATA: begin
				if (!sent_q) begin
					ws_d = ws_new;
					if (head_ent.idx == wsle_pkg::IDX_COUNT_LAST && ws_new == '0) begin
						fire = 1'b1;
					end else if (head_ent.idx == wsle_pkg::IDX_START_LAST) begin
						lb_d = ws_new;
					end else if (head_ent.idx == wsle_pkg::IDX_END_LAST) begin
						if (ws_new <= lb_q) begin
							fire = 1'b1;
						end else begin
							ws_d = ws_diff;
						end
					end else if (head_ent.idx >= wsle_pkg::IDX_DONE) begin
						fire      = 1'b1;
						res_found = 1'b1;
						res_start = lb_q;
						res_len   = ws_new;
					end
				end
				if (head_ent.last && !fire && !sent_q) begin
					fire = 1'b1;
				end
				sent_d = (sent_q || fire) && !head_ent.last;
			end
			wsle_pkg::OP_FAIL: begin
				fire   = 1'b1;
				sent_d = 1'b0;
			end
			wsle_pkg::OP_END: begin
				fire   = !sent_q;
				sent_d = 1'b0;
			end
			default: begin
				sent_d = 1'b0;
			end
		endcase
	end

	// extractor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q <= 1'b0;
		end else if (pop) begin
			sent_q <= sent_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ws_q <= ws_d;
			lb_q <= lb_d;
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop && fire) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && fire) begin
			found_q <= res_found;
			start_q <= res_start;
			len_q   <= res_len;
		end
	end

	assign out_valid  = vld_q;
	assign out_found  = found_q;
	assign out_start  = start_q;
	assign out_length = len_q;

	`WSLE_ASSERT(a_b_fail_zero, !(vld_q && !found_q && {start_q, len_q} != '0), "fail not zero")
	`WSLE_ASSERT(a_b_len_nonzero, !(vld_q && found_q && len_q == '0), "found loop with zero length")
	`WSLE_ASSERT_NEXT(a_b_last_rearms, pop && head_ent.last, !sent_q, "not rearmed after last")

endmodule

>>> hw/rtl/wav_sampler_loop_extractor_core.sv
`timescale 1ns / 1ps

// RIFF/WAVE sampler loop extractor. One file byte is taken per clock cycle on s_axis,
// with s_tlast on the final byte; the parser front end walks the RIFF and WAVE tags and
// the chunk list, and hands the bytes of the first smpl chunk through a two-entry queue
// to the loop extractor, which gives exactly one transaction per file on m_axis: found on
// m_tuser plus loop start and length on m_tdata, or found=0 with zero fields on a bad tag,
// a zero loop count, an empty first loop or a file that ends undecided. A result passes
// through the queue and then the output register before it is offered on m_axis.
// Input stalls only when m_tready is held low long enough for the queue to fill.
module wav_sampler_loop_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] loop_start, [63:32] loop_length
	output logic        m_tuser    // found
);

	logic            q_full;
	logic            push;
	wsle_pkg::qent_t push_ent;
	logic            head_valid;
	wsle_pkg::qent_t head_ent;
	logic            pop;
	logic            found;
	logic [31:0]     loop_start;
	logic [31:0]     loop_length;

	// chunk walker
	wsle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_ent (push_ent)
	);

	// decoupling queue
	wsle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ent   (push_ent),
		.full       (q_full),
		.head_valid (head_valid),
		.head_ent   (head_ent),
		.pop        (pop)
	);

	// loop extractor and result register
	wsle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_ent   (head_ent),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_found  (found),
		.out_start  (loop_start),
		.out_length (loop_length)
	);

	assign m_tdata = {loop_length, loop_start};
	assign m_tuser = found;

endmodule

>>> tb/wav_sampler_loop_extractor_core_checker.sv
`timescale 1ns / 1ps

module wav_sampler_loop_extractor_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // [31:0] loop_start, [63:32] loop_length
	input  logic        m_tuser,   // found
	output int          mismatches,
	output int          loops_pending,
	output int          loops_checked,
	output int          loops_found
);

	// four-character tags, first character in the low byte
	localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
	localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
	localparam logic [31:0] SMPL_TAG = 32'h6C70_6D73;

	typedef struct packed {
		logic        found;
		logic [31:0] start;
		logic [31:0] length;
	} loop_info_t;

	// parser state mirrored from the block
	wsle_pkg::front_state_t phase;
	logic [5:0]   byte_idx;
	logic [31:0]  word_sr;
	logic         id_is_smpl;
	logic [32:0]  skip_left;
	logic [31:0]  loop_first;
	logic         outcome_done;

	// one entry per file outcome still to be seen on m_axis
	loop_info_t   loop_expect_q[$];

	function automatic void clear_parser();
		phase        = wsle_pkg::FS_HEADER;
		byte_idx     = '0;
		word_sr      = '0;
		id_is_smpl   = 1'b0;
		skip_left    = '0;
		loop_first   = '0;
		outcome_done = 1'b0;
	endfunction

	function automatic void open_chunk_header();
		phase      = wsle_pkg::FS_CHUNK;
		byte_idx   = '0;
		id_is_smpl = 1'b1;
	endfunction

	// advances the parser by one file byte, returns 1 when the file outcome is decided
	function automatic logic parse_wav_byte(input logic [7:0] value, input logic is_last,
			output loop_info_t res);
		logic       hit;
		logic [5:0] idx;
		hit = 1'b0;
		res = '0;
		idx = byte_idx;
		if (!outcome_done) begin
			case (phase)
				wsle_pkg::FS_HEADER: begin
					if ((idx < 6'd4 && value != RIFF_TAG[8 * idx[1:0] +: 8]) ||
							(idx >= 6'd8 && idx < wsle_pkg::HDR_LEN &&
							value != WAVE_TAG[8 * idx[1:0] +: 8])) begin
						hit = 1'b1;
					end else begin
						idx = idx + 6'd1;
						byte_idx = idx;
						if (idx >= wsle_pkg::HDR_LEN)
							open_chunk_header();
					end
				end
				wsle_pkg::FS_CHUNK: begin
					if (idx < 6'd4 && value != SMPL_TAG[8 * idx[1:0] +: 8])
						id_is_smpl = 1'b0;
					word_sr = {value, word_sr[31:8]};
					idx = idx + 6'd1;
					byte_idx = idx;
					if (idx >= wsle_pkg::CHUNK_HDR_LEN) begin
						if (id_is_smpl) begin
							phase = wsle_pkg::FS_SAMPLER;
							byte_idx = '0;
						end else begin
							// odd sizes carry one pad byte
							skip_left = {1'b0, word_sr} + 33'(word_sr[0]);
							if (skip_left == '0)
								open_chunk_header();
							else
								phase = wsle_pkg::FS_SKIP;
						end
					end
				end
				wsle_pkg::FS_SKIP: begin
					if (skip_left != '0)
						skip_left = skip_left - 33'd1;
					if (skip_left == '0)
						open_chunk_header();
				end
				wsle_pkg::FS_SAMPLER: begin
					if (idx <= wsle_pkg::IDX_END_LAST)
						word_sr = {value, word_sr[31:8]};
					if (idx == wsle_pkg::IDX_COUNT_LAST && word_sr == '0) begin
						hit = 1'b1;
					end else if (idx == wsle_pkg::IDX_START_LAST) begin
						loop_first = word_sr;
					end else if (idx == wsle_pkg::IDX_END_LAST) begin
						if (word_sr <= loop_first)
							hit = 1'b1;
						else
							word_sr = word_sr - loop_first;
					end else if (idx >= wsle_pkg::IDX_DONE) begin
						hit = 1'b1;
						res.found  = 1'b1;
						res.start  = loop_first;
						res.length = word_sr;
					end
					if (idx < wsle_pkg::IDX_MAX)
						byte_idx = idx + 6'd1;
				end
				default: begin
					hit = 1'b1;
				end
			endcase
			if (hit)
				outcome_done = 1'b1;
		end
		// the final byte closes the file, undecided files report not found
		if (is_last) begin
			if (!outcome_done)
				hit = 1'b1;
			clear_parser();
		end
		return hit;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		mismatches    = 0;
		loops_pending = 0;
		loops_checked = 0;
		loops_found   = 0;
		clear_parser();
	end

	// predict on input transactions, compare on output transactions
	always @(posedge clk) begin : watch
		loop_info_t want;
		logic       hit;
		if (!arst_n) begin
			clear_parser();
			loop_expect_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				hit = parse_wav_byte(s_tdata[7:0], s_tlast, want);
				if (hit)
					loop_expect_q = {loop_expect_q, want};
			end
			if (m_tvalid && m_tready) begin
				if (loop_expect_q.size() == 0) begin
					$error("result transaction with no outcome pending: m_tdata 0x%016h",
						m_tdata);
					mismatches++;
				end else begin
					want = loop_expect_q.pop_front();
					check_field("found", 32'(want.found), 32'(m_tuser));
					check_field("loop_start", want.start, m_tdata[31:0]);
					check_field("loop_length", want.length, m_tdata[63:32]);
					loops_checked++;
					if (want.found)
						loops_found++;
				end
			end
		end
		loops_pending = loop_expect_q.size();
	end

endmodule

>>> tb/wav_sampler_loop_extractor_core_tb.sv
`timescale 1ns / 1ps

module wav_sampler_loop_extractor_core_tb;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int TOTAL_BYTES    = 550;

	// tags for building files, first character in the low byte
	localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
	localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
	localparam logic [31:0] SMPL_TAG = 32'h6C70_6D73;
	localparam logic [31:0] FMT_TAG  = 32'h2074_6D66;
	localparam logic [31:0] DATA_TAG = 32'h6174_6164;
	localparam logic [31:0] NEAR_TAG = 32'h4C70_6D73;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] byte_value
	logic        s_tlast;   // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [31:0] loop_start, [63:32] loop_length
	logic        m_tuser;   // found

	int mismatches;
	int loops_pending;
	int loops_checked;
	int loops_found;

	logic [7:0] wav_q[$];
	int         files_sent;
	int         bytes_sent;
	bit         tx_gaps;
	bit         rx_gaps;
	bit         rx_hold_req;
	bit         run_active;
	int         quiet_cycles;

	wav_sampler_loop_extractor_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	wav_sampler_loop_extractor_core_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.mismatches    (mismatches),
		.loops_pending (loops_pending),
		.loops_checked (loops_checked),
		.loops_found   (loops_found)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// file building helpers, words go out little-endian
	function automatic void put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			wav_q = {wav_q, w[8 * i +: 8]};
	endfunction

	function automatic void put_header();
		put_word(RIFF_TAG);
		put_word($urandom);
		put_word(WAVE_TAG);
	endfunction

	function automatic void put_random(input int n);
		repeat (n) wav_q = {wav_q, 8'($urandom)};
	endfunction

	// body is only written for small sizes, large ones are meant to be cut off
	function automatic void put_plain_chunk(input logic [31:0] id, input logic [31:0] size);
		put_word(id);
		put_word(size);
		if (size <= 32'd64)
			put_random(int'(size) + int'(size[0]));
	endfunction

	function automatic void put_sampler(input logic [31:0] decl, input logic [31:0] count,
			input logic [31:0] lstart, input logic [31:0] lend);
		logic [7:0] body [60];
		for (int i = 0; i < 60; i++)
			body[i] = 8'($urandom);
		for (int i = 0; i < 4; i++) begin
			body[28 + i] = count[8 * i +: 8];
			body[44 + i] = lstart[8 * i +: 8];
			body[48 + i] = lend[8 * i +: 8];
		end
		put_word(SMPL_TAG);
		put_word(decl);
		for (int i = 0; i < 60; i++)
			wav_q = {wav_q, body[i]};
	endfunction

	function automatic void cut_wav(input int n);
		while (wav_q.size() > n)
			void'(wav_q.pop_back());
	endfunction

	// mostly well-formed files with random content, plus noise, bad tags and cut files
	function automatic void build_random_wav();
		int          kind;
		int          nchunks;
		int          p;
		logic [31:0] id;
		logic [31:0] size;
		logic [31:0] decl;
		logic [31:0] count;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] t;
		bit          cut_short;
		wav_q.delete();
		cut_short = 1'b0;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			put_random($urandom_range(1, 16));
			return;
		end
		put_header();
		if (kind < 20) begin
			p = $urandom_range(0, 7);
			if (p >= 4)
				p += 4;
			wav_q[p] = wav_q[p] ^ 8'($urandom_range(1, 255));
		end
		nchunks = $urandom_range(0, 3);
		for (int c = 0; c < nchunks && !cut_short; c++) begin
			case ($urandom_range(0, 3))
				0: id = FMT_TAG;
				1: id = DATA_TAG;
				2: id = SMPL_TAG ^ (32'h1 << $urandom_range(0, 31));
				default: id = $urandom;
			endcase
			if ($urandom_range(0, 9) == 0) begin
				size = $urandom;
				cut_short = 1'b1;
			end else begin
				size = $urandom_range(0, 24);
			end
			put_plain_chunk(id, size);
			if (cut_short)
				put_random($urandom_range(0, 12));
		end
		if (cut_short)
			return;
		case ($urandom_range(0, 3))
			0: decl = '0;
			1: decl = $urandom;
			default: decl = 32'd60;
		endcase
		case ($urandom_range(0, 5))
			0: count = '0;
			1: count = 32'd1;
			2: count = '1;
			default: count = $urandom;
		endcase
		a = $urandom;
		b = $urandom;
		case ($urandom_range(0, 7))
			0: b = a;
			1: ;
			2, 3, 4: begin
				a = $urandom_range(0, 4096);
				b = a + 32'($urandom_range(1, 4096));
			end
			default: begin
				if (a > b) begin
					t = a;
					a = b;
					b = t;
				end
				if (a == b)
					b = a + 32'd1;
			end
		endcase
		put_sampler(decl, count, a, b);
		put_random($urandom_range(0, 6));
		if (kind >= 20 && kind < 32)
			cut_wav($urandom_range(1, wav_q.size()));
	endfunction

	// one byte per input transaction, random gap before it when gaps are enabled
	task automatic send_byte(input logic [7:0] value, input logic is_last);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_wav(input bit allow_gaps);
		tx_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
		for (int i = 0; i < wav_q.size(); i++)
			send_byte(wav_q[i], i == wav_q.size() - 1);
		files_sent++;
	endtask

	// sender pauses until every outcome has been seen
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (loops_pending != 0);
		@(posedge clk);
	endtask

	// result sink with random stalls and an occasional long hold-off
	initial begin : result_sink
		int wait_n;
		int taken;
		taken    = 0;
		rx_gaps  = 1'b1;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				wait_n = HOLD_CYCLES;
			end else if (rx_gaps) begin
				wait_n = $urandom_range(0, 10);
			end else begin
				wait_n = 0;
			end
			if (wait_n > 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			taken++;
			if (taken % 8 == 0)
				rx_gaps = ($urandom_range(0, 2) != 0);
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!run_active || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (run_active && quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		tx_gaps      = 1'b0;
		rx_hold_req  = 1'b0;
		run_active   = 1'b0;
		quiet_cycles = 0;
		files_sent   = 0;
		bytes_sent   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_active = 1'b1;

		// single-byte files: wrong first tag byte, then an undecided one
		wav_q.delete();
		wav_q = {wav_q, 8'h00};
		send_wav(1);
		wav_q.delete();
		wav_q = {wav_q, RIFF_TAG[7:0]};
		send_wav(1);

		// tag errors on the last RIFF byte and on both ends of WAVE
		wav_q.delete();
		put_header();
		wav_q[3] = 8'h00;
		put_random(5);
		send_wav(1);
		wav_q.delete();
		put_header();
		wav_q[8] = wav_q[8] ^ 8'h80;
		send_wav(1);
		wav_q.delete();
		put_header();
		wav_q[11] = 8'hFF;
		put_random(1);
		send_wav(1);

		// header only, no chunk at all
		wav_q.delete();
		put_header();
		send_wav(1);

		// smpl right after the header, widest loop, bytes after the decision
		wav_q.delete();
		put_header();
		put_sampler(32'd60, 32'd1, 32'h0, 32'hFFFF_FFFF);
		put_random(3);
		send_wav(1);

		// zero-size, odd-size and near-miss chunks, smpl size ignored, success on final byte
		wav_q.delete();
		put_header();
		put_plain_chunk(FMT_TAG, 32'd0);
		put_plain_chunk(NEAR_TAG, 32'd3);
		put_plain_chunk($urandom, 32'd1);
		put_sampler(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_wav(1);

		// zero loop count decided on the final byte
		wav_q.delete();
		put_header();
		put_sampler(32'd60, 32'd0, 32'd5, 32'd10);
		cut_wav(12 + 8 + 32);
		send_wav(1);

		// empty loop: end equal to start
		wav_q.delete();
		put_header();
		put_sampler(32'd60, 32'd2, 32'd100, 32'd100);
		put_random(2);
		send_wav(1);

		// truncated huge chunk, file ending inside the smpl data
		wav_q.delete();
		put_header();
		put_plain_chunk(DATA_TAG, 32'hFFFF_FFFF);
		put_random(10);
		send_wav(1);
		wav_q.delete();
		put_header();
		put_sampler(32'd60, 32'd1, 32'h1234_5678, 32'h9ABC_DEF0);
		cut_wav(12 + 8 + 41);
		send_wav(1);
		drain();

		// long sink hold-off while one-byte files keep coming, so the input stalls
		rx_hold_req = 1'b1;
		repeat (12) begin
			wav_q.delete();
			put_random(1);
			send_wav(0);
		end
		drain();

		// random files up to the byte budget
		while (bytes_sent < TOTAL_BYTES) begin
			build_random_wav();
			send_wav(1);
			if ($urandom_range(0, 15) == 0)
				drain();
		end
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		run_active = 1'b0;

		$display("covered %0d files in %0d bytes: tag errors, zero counts, empty loops,",
			files_sent, bytes_sent);
		$display("truncated files and back-pressure; %0d outcomes checked, %0d loops found",
			loops_checked, loops_found);
		if (mismatches == 0 && loops_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
